// ===== design/keyed_semaphore_table_assert.svh =====
// Assertion macros shared by the checker of the semaphore table.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef KEYED_SEMAPHORE_TABLE_ASSERT_SVH
`define KEYED_SEMAPHORE_TABLE_ASSERT_SVH

// same-cycle implication, off during reset
`define KST_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("keyed_semaphore_table: assertion failed");

// next-cycle implication, off during reset
`define KST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("keyed_semaphore_table: assertion failed");

`endif

// ===== design/kst_pkg.sv =====
// Package of the keyed semaphore table: codes, entry layout and the types
// passed to the shared compare/add unit. No dependencies.
package kst_pkg;

  localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ACT_GET     = 2'd0,
    ACT_OPERATE = 2'd1,
    ACT_REMOVE  = 2'd2
  } act_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_ERROR = 2'd1,
    ST_WAIT  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_RESP
  } state_e;

  typedef struct packed {
    logic        used;
    logic [31:0] key;
    logic [30:0] value;
  } entry_t;

  typedef struct packed {
    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [30:0] value;
    logic [15:0] delta;
  } unit_in_t;

  typedef struct packed {
    logic        key_eq;
    logic        wait_req;
    logic [30:0] value;
  } unit_out_t;

endpackage

// ===== design/kst_if.sv =====
// Handshake channels of the keyed semaphore table: request and response.
// No dependencies.
interface kst_req_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [31:0] key;
  logic        [5:0]  sem_id;
  logic signed [15:0] delta;
  logic        [15:0] sem_number;
  logic        [15:0] count;
  logic        [15:0] command;

  modport source (output valid, action, key, sem_id, delta, sem_number, count, command,
                  input ready);
  modport sink   (input valid, action, key, sem_id, delta, sem_number, count, command,
                  output ready);
endinterface

interface kst_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [5:0] entry_index;

  modport source (output valid, status, entry_index, input ready);
  modport sink   (input valid, status, entry_index, output ready);
endinterface

// ===== design/kst_mem.sv =====
// Entry store of the semaphore table: one write port, one read port with
// registered read data. Uses kst_pkg::entry_t.
module kst_mem #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrW-1:0]    waddr_i,
  input  kst_pkg::entry_t     wdata_i,
  input  logic                re_i,
  input  logic [AddrW-1:0]    raddr_i,
  output kst_pkg::entry_t     rdata_o
);

  kst_pkg::entry_t mem_q [Depth];
  kst_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/kst_unit.sv =====
// Shared compare/add unit: key equality for the get scan and the
// saturating add or conditional take for operate. Uses kst_pkg.
module kst_unit (
  input  kst_pkg::unit_in_t  op_i,
  output kst_pkg::unit_out_t res_o
);

  logic [31:0] sum;
  logic [16:0] mag;

  always_comb begin
    sum = {1'b0, op_i.value} + {16'd0, op_i.delta};
    mag = 17'h1_0000 - {1'b0, op_i.delta};
    res_o.key_eq   = (op_i.key_a == op_i.key_b);
    res_o.wait_req = 1'b0;
    if (op_i.delta[15]) begin
      // take only when the value covers the magnitude
      res_o.wait_req = (op_i.value < {14'd0, mag});
      res_o.value    = op_i.value - {14'd0, mag};
    end else if (sum[31]) begin
      res_o.value = kst_pkg::VALUE_MAX;
    end else begin
      res_o.value = sum[30:0];
    end
  end

endmodule

// ===== design/keyed_semaphore_table.sv =====
// Keyed semaphore table: TABLE_ENTRIES counting semaphores named by 32-bit keys.
// Request channel req_i carries action, key, sem_id, delta, sem_number, count and
// command; the response channel rsp_o returns status (done, error, wait) and the
// entry index found or claimed by a get. One response per request, in order.
// One request is in flight at a time; req_i.ready is high only while idle.
// A get scans the store one entry per cycle through the single read
// port and stops when the key is found. Operate and remove go through
// read, update and respond; a request rejected by its fields responds
// in the cycle after it is taken. The response holds in its register
// until rsp_o.ready.
// After reset the block clears the used flag of every entry, one entry a
// cycle, with req_i.ready low.
// Depends on kst_pkg, kst_if, kst_mem and kst_unit.
module keyed_semaphore_table #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  kst_req_if.sink        req_i,
  kst_rsp_if.source      rsp_o
);

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] LAST_IDX  = CW'(TABLE_ENTRIES - 1);
  localparam logic [CW-1:0] NUM_ENTRY = CW'(TABLE_ENTRIES);

  kst_pkg::state_e  state_q, state_d;
  logic [CW-1:0]    scan_q, scan_d;
  logic             chk_vld_q, chk_vld_d;
  logic [IW-1:0]    chk_idx_q, chk_idx_d;
  logic             free_vld_q, free_vld_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic             out_vld_q, out_vld_d;
  kst_pkg::status_e status_q, status_d;
  logic [IW-1:0]    idx_q, idx_d;

  // latched request
  kst_pkg::act_e    act_q;
  logic [31:0]      key_q;
  logic [IW-1:0]    id_q;
  logic [15:0]      delta_q;

  logic             req_fire, rsp_fire, latch;
  logic             id_ok;
  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  kst_pkg::entry_t  mem_wdata, mem_rdata;
  kst_pkg::unit_in_t  unit_in;
  kst_pkg::unit_out_t unit_out;

  kst_mem #(
    .Depth (TABLE_ENTRIES),
    .AddrW (IW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign unit_in.key_a = mem_rdata.key;
  assign unit_in.key_b = key_q;
  assign unit_in.value = mem_rdata.value;
  assign unit_in.delta = delta_q;

  kst_unit u_unit (
    .op_i  (unit_in),
    .res_o (unit_out)
  );

  assign req_i.ready       = (state_q == kst_pkg::S_IDLE);
  assign req_fire          = req_i.valid && req_i.ready;
  assign rsp_o.valid       = out_vld_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.entry_index = 6'(idx_q);
  assign rsp_fire          = rsp_o.valid && rsp_o.ready;
  assign id_ok             = ({26'd0, req_i.sem_id} < 32'(TABLE_ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kst_pkg::S_CLEAR;
      scan_q     <= '0;
      chk_vld_q  <= 1'b0;
      free_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      chk_vld_q  <= chk_vld_d;
      free_vld_q <= free_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    free_idx_q <= free_idx_d;
    status_q   <= status_d;
    idx_q      <= idx_d;
    if (latch) begin
      act_q   <= kst_pkg::act_e'(req_i.action);
      key_q   <= req_i.key;
      id_q    <= IW'(req_i.sem_id);
      delta_q <= req_i.delta;
    end
  end

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    chk_vld_d  = 1'b0;
    chk_idx_d  = chk_idx_q;
    free_vld_d = free_vld_q;
    free_idx_d = free_idx_q;
    out_vld_d  = out_vld_q;
    status_d   = status_q;
    idx_d      = idx_q;
    latch      = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;

    case (state_q)
      kst_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = scan_q[IW-1:0];
        scan_d    = scan_q + 1'b1;
        if (scan_q == LAST_IDX) begin
          scan_d  = '0;
          state_d = kst_pkg::S_IDLE;
        end
      end

      kst_pkg::S_IDLE: begin
        if (req_fire) begin
          latch     = 1'b1;
          out_vld_d = 1'b1;
          status_d  = kst_pkg::ST_ERROR;
          idx_d     = '0;
          state_d   = kst_pkg::S_RESP;
          case (kst_pkg::act_e'(req_i.action))
            kst_pkg::ACT_GET: begin
              if (req_i.count == 16'd1) begin
                out_vld_d  = 1'b0;
                scan_d     = '0;
                free_vld_d = 1'b0;
                state_d    = kst_pkg::S_SCAN;
              end
            end
            kst_pkg::ACT_OPERATE: begin
              if (req_i.count == 16'd1 && req_i.sem_number == 16'd0 && id_ok) begin
                out_vld_d = 1'b0;
                state_d   = kst_pkg::S_READ;
              end
            end
            kst_pkg::ACT_REMOVE: begin
              if (req_i.command == 16'd0 && id_ok) begin
                out_vld_d = 1'b0;
                state_d   = kst_pkg::S_READ;
              end
            end
            default: begin
              state_d = kst_pkg::S_RESP;
            end
          endcase
        end
      end

      kst_pkg::S_READ: begin
        mem_re    = 1'b1;
        mem_raddr = id_q;
        state_d   = kst_pkg::S_EXEC;
      end

      kst_pkg::S_EXEC: begin
        out_vld_d = 1'b1;
        idx_d     = '0;
        state_d   = kst_pkg::S_RESP;
        if (!mem_rdata.used) begin
          status_d = kst_pkg::ST_ERROR;
        end else if (act_q == kst_pkg::ACT_REMOVE) begin
          mem_we    = 1'b1;
          mem_waddr = id_q;
          status_d  = kst_pkg::ST_DONE;
        end else if (unit_out.wait_req) begin
          status_d = kst_pkg::ST_WAIT;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = id_q;
          mem_wdata.used  = 1'b1;
          mem_wdata.key   = mem_rdata.key;
          mem_wdata.value = unit_out.value;
          status_d        = kst_pkg::ST_DONE;
        end
      end

      kst_pkg::S_SCAN: begin
        // issue the next read while checking the entry read last cycle
        if (scan_q < NUM_ENTRY) begin
          mem_re    = 1'b1;
          mem_raddr = scan_q[IW-1:0];
          chk_vld_d = 1'b1;
          chk_idx_d = scan_q[IW-1:0];
          scan_d    = scan_q + 1'b1;
        end
        if (chk_vld_q) begin
          if (mem_rdata.used && unit_out.key_eq) begin
            out_vld_d = 1'b1;
            status_d  = kst_pkg::ST_DONE;
            idx_d     = chk_idx_q;
            chk_vld_d = 1'b0;
            state_d   = kst_pkg::S_RESP;
          end else if (!mem_rdata.used && !free_vld_q) begin
            free_vld_d = 1'b1;
            free_idx_d = chk_idx_q;
          end
        end else if (scan_q == NUM_ENTRY) begin
          // no match anywhere: claim the lowest free entry
          out_vld_d = 1'b1;
          state_d   = kst_pkg::S_RESP;
          if (free_vld_q) begin
            mem_we         = 1'b1;
            mem_waddr      = free_idx_q;
            mem_wdata.used = 1'b1;
            mem_wdata.key  = key_q;
            status_d       = kst_pkg::ST_DONE;
            idx_d          = free_idx_q;
          end else begin
            status_d = kst_pkg::ST_ERROR;
            idx_d    = '0;
          end
        end
      end

      kst_pkg::S_RESP: begin
        if (rsp_fire) begin
          out_vld_d = 1'b0;
          state_d   = kst_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = kst_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/kst_checker.sv =====
// Port-level checker of the keyed semaphore table, bound to the top level.
// Uses kst_pkg and the macros of keyed_semaphore_table_assert.svh.
`include "keyed_semaphore_table_assert.svh"

module kst_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       req_valid_i,
  input logic       req_ready_i,
  input logic       rsp_valid_i,
  input logic       rsp_ready_i,
  input logic [1:0] rsp_status_i,
  input logic [5:0] rsp_entry_index_i
);

  // a waiting response word holds until taken
  `KST_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i)
  // one request in flight: never take a word while a response is pending
  `KST_ASSERT_NOW(a_one_in_flight, req_ready_i, !rsp_valid_i)
  // after a request is taken, the next is refused until its response goes
  `KST_ASSERT_NEXT(a_busy_after_take, req_valid_i && req_ready_i, !req_ready_i)
  // only a successful get reports an index
  `KST_ASSERT_NOW(a_idx_zero, rsp_valid_i && rsp_status_i != kst_pkg::ST_DONE,
                  rsp_entry_index_i == 6'd0)

endmodule

bind keyed_semaphore_table kst_checker u_kst_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .req_valid_i       (req_i.valid),
  .req_ready_i       (req_i.ready),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .rsp_status_i      (rsp_o.status),
  .rsp_entry_index_i (rsp_o.entry_index)
);

// ===== dv/keyed_semaphore_table_tb.sv =====
`timescale 1ns / 100ps
// Testbench of keyed_semaphore_table: directed and random request words are
// checked against an in-bench table model. Depends on kst_pkg, kst_if and the RTL.
module keyed_semaphore_table_tb;

  localparam int          TABLE_ENTRIES = 64;
  localparam logic [1:0]  ACT_UNKNOWN   = 2'd3;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          LIMIT_CYCLES  = 400000;
  localparam int          DRAIN_CYCLES  = TABLE_ENTRIES + 16;
  localparam int          HOLD_CYCLES   = 300;

  typedef struct {
    logic [1:0]  action;
    logic [31:0] key;
    logic [5:0]  sem_id;
    logic [15:0] delta;
    logic [15:0] sem_number;
    logic [15:0] count;
    logic [15:0] command;
  } sem_req_t;

  typedef struct {
    kst_pkg::status_e status;
    logic [5:0]       index;
  } sem_rsp_t;

  // Table model plus the queue of responses still owed by the block.
  class sem_table_scoreboard;
    bit          used_tab[TABLE_ENTRIES];
    logic [31:0] key_tab[TABLE_ENTRIES];
    logic [30:0] value_tab[TABLE_ENTRIES];
    sem_rsp_t    owed_rsp_q[$];
    int          mismatches;

    function new();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        used_tab[i]  = 1'b0;
        key_tab[i]   = '0;
        value_tab[i] = '0;
      end
      mismatches = 0;
    endfunction

    function int pending_count();
      return owed_rsp_q.size();
    endfunction

    function void note_request(sem_req_t w);
      sem_rsp_t r;
      bit       found;
      int       d;
      longint   v;
      r.status = kst_pkg::ST_ERROR;
      r.index  = '0;
      found    = 1'b0;
      case (w.action)
        kst_pkg::ACT_GET: begin
          if (w.count == 16'd1) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (!found && used_tab[i] && key_tab[i] == w.key) begin
                found    = 1'b1;
                r.status = kst_pkg::ST_DONE;
                r.index  = 6'(i);
              end
            end
            // no match: claim the lowest free entry
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (!found && !used_tab[i]) begin
                found        = 1'b1;
                used_tab[i]  = 1'b1;
                key_tab[i]   = w.key;
                value_tab[i] = '0;
                r.status     = kst_pkg::ST_DONE;
                r.index      = 6'(i);
              end
            end
          end
        end
        kst_pkg::ACT_OPERATE: begin
          if (w.count == 16'd1 && w.sem_number == 16'd0 && used_tab[w.sem_id]) begin
            d = $signed(w.delta);
            v = value_tab[w.sem_id];
            r.status = kst_pkg::ST_DONE;
            if (d < 0) begin
              if (v < -d) r.status = kst_pkg::ST_WAIT;
              else value_tab[w.sem_id] = 31'(v + d);
            end else if (v + d > longint'(kst_pkg::VALUE_MAX)) begin
              value_tab[w.sem_id] = kst_pkg::VALUE_MAX;
            end else begin
              value_tab[w.sem_id] = 31'(v + d);
            end
          end
        end
        kst_pkg::ACT_REMOVE: begin
          if (w.command == 16'd0 && used_tab[w.sem_id]) begin
            used_tab[w.sem_id]  = 1'b0;
            key_tab[w.sem_id]   = '0;
            value_tab[w.sem_id] = '0;
            r.status = kst_pkg::ST_DONE;
          end
        end
        default: ;
      endcase
      owed_rsp_q.push_back(r);
    endfunction

    function void check_response(logic [1:0] status, logic [5:0] index);
      sem_rsp_t r;
      if (owed_rsp_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected response: status %0d index %0d", status, index);
        return;
      end
      r = owed_rsp_q.pop_front();
      if (status !== r.status || index !== r.index) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("response mismatch: expected status %0d index %0d, got status %0d index %0d",
                   r.status, r.index, status, index);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_left     = 0;
  int   cycle_count   = 0;
  logic [31:0] key_pool[32];

  sem_table_scoreboard sb = new();

  kst_req_if req_if ();
  kst_rsp_if rsp_if ();

  keyed_semaphore_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin : monitor
    sem_req_t seen;
    if (rst_n) begin
      if (req_if.valid && req_if.ready) begin
        seen.action     = req_if.action;
        seen.key        = req_if.key;
        seen.sem_id     = req_if.sem_id;
        seen.delta      = req_if.delta;
        seen.sem_number = req_if.sem_number;
        seen.count      = req_if.count;
        seen.command    = req_if.command;
        sb.note_request(seen);
      end
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.status, rsp_if.entry_index);
    end
  end

  // Response side: random stalls, or a long hold-off while hold_left runs down.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic sem_req_t make_req(logic [1:0] action, logic [31:0] key,
                                        logic [5:0] id, logic [15:0] delta,
                                        logic [15:0] sem_number, logic [15:0] count,
                                        logic [15:0] command);
    sem_req_t w;
    w.action     = action;
    w.key        = key;
    w.sem_id     = id;
    w.delta      = delta;
    w.sem_number = sem_number;
    w.count      = count;
    w.command    = command;
    return w;
  endfunction

  // Mostly land on a used entry, so operate and remove get past the checks.
  function automatic logic [5:0] pick_id();
    int start;
    start = $urandom_range(TABLE_ENTRIES - 1);
    if ($urandom_range(99) < 85) begin
      for (int i = 0; i < TABLE_ENTRIES; i++)
        if (sb.used_tab[(start + i) % TABLE_ENTRIES]) return 6'((start + i) % TABLE_ENTRIES);
    end
    return 6'(start);
  endfunction

  function automatic sem_req_t random_word(int remove_pct);
    sem_req_t w;
    int       pick;
    w.action     = kst_pkg::ACT_GET;
    w.key        = $urandom();
    w.sem_id     = 6'($urandom_range(TABLE_ENTRIES - 1));
    w.delta      = 16'($urandom_range(16'hFFFF));
    w.sem_number = 16'($urandom_range(16'hFFFF));
    w.count      = 16'($urandom_range(16'hFFFF));
    w.command    = 16'($urandom_range(16'hFFFF));
    pick = $urandom_range(99);
    if (pick < 6) begin
      // noise: any action, fields left random
      w.action = 2'($urandom_range(3));
      if ($urandom_range(1)) w.count = 16'd1;
    end else if (pick < 40) begin
      w.action = kst_pkg::ACT_GET;
      w.count  = 16'd1;
      if ($urandom_range(99) < 75) w.key = key_pool[$urandom_range(31)];
    end else if (pick < 100 - remove_pct) begin
      w.action     = kst_pkg::ACT_OPERATE;
      w.count      = 16'd1;
      w.sem_number = 16'd0;
      w.sem_id     = pick_id();
      case ($urandom_range(9))
        0:       w.delta = 16'd0;
        1, 2, 3: w.delta = 16'($urandom_range(1, 40));
        4, 5, 6: w.delta = 16'(-$urandom_range(1, 40));
        7:       w.delta = $urandom_range(1) ? 16'h7FFF : 16'h8000;
        8:       w.delta = 16'($urandom_range(1, 2000));
        default: ;
      endcase
    end else begin
      w.action  = kst_pkg::ACT_REMOVE;
      w.command = 16'd0;
      w.sem_id  = pick_id();
    end
    return w;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_word(sem_req_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.action     <= w.action;
    req_if.key        <= w.key;
    req_if.sem_id     <= w.sem_id;
    req_if.delta      <= w.delta;
    req_if.sem_number <= w.sem_number;
    req_if.count      <= w.count;
    req_if.command    <= w.command;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and hold until every owed response is back.
  task automatic drain_responses();
    req_if.valid <= 1'b0;
    do @(negedge clk); while (sb.pending_count() != 0);
  endtask

  task automatic run_directed();
    sem_req_t words[$];
    words.push_back(make_req(kst_pkg::ACT_GET, 32'h0000_0000,
                             6'd5, 16'h1234, 16'hFFFF, 16'd1, 16'hFFFF));
    words.push_back(make_req(kst_pkg::ACT_GET, 32'h7FFF_FFFF,
                             6'd0, 16'h0, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_GET, 32'h8000_0000,
                             6'd63, 16'h0, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_GET, 32'hFFFF_FFFF,
                             6'd0, 16'hFFFF, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_GET, 32'h0000_0000,
                             6'd0, 16'h0, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_GET, 32'h1111_1111,
                             6'd0, 16'h0, 16'd0, 16'd0, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_GET, 32'h1111_1111,
                             6'd0, 16'h0, 16'd0, 16'hFFFF, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd0, 16'h0000, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd0, 16'h7FFF, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd0, 16'h8000, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd0, 16'h8001, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd1, 16'hFFFF, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd0, 16'h0001, 16'd1, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd0, 16'h0001, 16'hFFFF, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd0, 16'h0001, 16'd0, 16'd0, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'h0,
                             6'd63, 16'h0001, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_REMOVE, 32'h0,
                             6'd63, 16'h0, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_REMOVE, 32'h0,
                             6'd1, 16'h0, 16'd0, 16'd1, 16'd1));
    words.push_back(make_req(kst_pkg::ACT_REMOVE, 32'h0,
                             6'd1, 16'h0, 16'd0, 16'd1, 16'hFFFF));
    words.push_back(make_req(kst_pkg::ACT_REMOVE, 32'h0,
                             6'd1, 16'h0, 16'd0, 16'hFFFF, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_GET, 32'h1234_5678,
                             6'd0, 16'h0, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(ACT_UNKNOWN, 32'h0, 6'd0, 16'h0, 16'd0, 16'd1, 16'd0));
    words.push_back(make_req(kst_pkg::ACT_OPERATE, 32'hFFFF_FFFF, 6'd2, 16'h0001, 16'd0, 16'd1,
                             16'hFFFF));
    foreach (words[i]) send_word(words[i]);
  endtask

  initial begin
    rst_n             = 1'b0;
    req_if.valid      = 1'b0;
    req_if.action     = kst_pkg::ACT_GET;
    req_if.key        = '0;
    req_if.sem_id     = '0;
    req_if.delta      = '0;
    req_if.sem_number = '0;
    req_if.count      = '0;
    req_if.command    = '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h8000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 32; i++) key_pool[i] = $urandom();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 26;
    recv_idle_pct = 78;
    run_directed();
    drain_responses();

    for (int i = 0; i < 200; i++) begin
      // stall the response side while requests keep coming
      if (i == 100) hold_left = HOLD_CYCLES;
      send_word(random_word(15));
    end

    send_idle_pct = 78;
    recv_idle_pct = 26;
    for (int i = 0; i < 200; i++) begin
      if (i == 100) drain_responses();
      send_word(random_word(15));
    end

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // fill the table with fresh keys so the full case shows up
    for (int i = 0; i < 70; i++)
      send_word(make_req(kst_pkg::ACT_GET, $urandom(), 6'($urandom_range(63)),
                         16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                         16'd1, 16'($urandom_range(16'hFFFF))));
    for (int i = 0; i < 150; i++) send_word(random_word(25));

    drain_responses();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
